### src/abbt_pkg.sv
// Shared constants and types for the averaged bang-bang thermostat.
`timescale 1ns / 1ps

package abbt_pkg;

	localparam int ADC_W  = 10;
	localparam int TEMP_W = 8;
	localparam int SUM_W  = 12;
	localparam int REG_W  = 8;
	localparam int IDX_W  = 1;

	// millivolt scale folded with the divide by ten: temp = adc * 500 / 1023
	localparam int MV_SCALE = 500;
	localparam int PROD_W   = 19;
	localparam int DIV_W    = 10;
	localparam logic [DIV_W:0]    ADC_DIV  = 11'd1023;
	localparam logic [TEMP_W-1:0] TEMP_MAX = 8'd255;

	// reciprocal precision used for the window mean
	localparam int AVG_SHIFT = 24;

	localparam logic [REG_W-1:0] SETPOINT_RST = 8'd60;
	localparam logic [REG_W-1:0] BAND_RST     = 8'd5;

	typedef enum logic [IDX_W-1:0] {
		REG_SETPOINT = 1'b0,
		REG_BAND     = 1'b1
	} cfg_reg_t;

endpackage

### src/abbt_ifs.sv
// Handshake interfaces for the sample and result channels.
`timescale 1ns / 1ps

interface abbt_sample_if;
	logic                          valid;
	logic                          ready;
	logic [abbt_pkg::ADC_W-1:0]    adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink   (input valid, input adc_sample, output ready);
endinterface

interface abbt_result_if;
	logic                          valid;
	logic                          ready;
	logic [abbt_pkg::TEMP_W-1:0]   average_temp;
	logic                          fan_on;
	logic                          heater_on;

	modport source (output valid, output average_temp, output fan_on, output heater_on,
		input ready);
	modport sink   (input valid, input average_temp, input fan_on, input heater_on,
		output ready);
endinterface

### src/averaged_bang_bang_thermostat.sv
// Top level of the averaged bang-bang thermostat.
//
// samples: one converter reading per transaction (valid/ready). Each reading is
// turned into whole degrees and summed; every WINDOW readings close a window.
// results: one transaction per closed window, carrying the truncated mean and
// the fan and heater drives after the hysteresis decision against
// setpoint +/- band. Readings that do not close a window give no result.
// cfg_we/cfg_index/cfg_data write setpoint (index 0) or band (index 1);
// write only while no window is in flight.
// Throughput: one reading per cycle while the result side is not stalled. The
// last reading of a window passes the input register, conversion stage,
// accumulate stage and result register before its result is valid.
// Reset clears the sum, the reading count, both drives and the pipeline, and
// loads setpoint 60 and band 5.
// A stalled result holds the whole pipeline: samples.ready follows
// !results.valid || results.ready, so nothing is dropped while the sink waits.
`timescale 1ns / 1ps

module averaged_bang_bang_thermostat #(
	parameter int WINDOW = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	abbt_sample_if.sink                   samples,
	abbt_result_if.source                 results,
	input  logic                          cfg_we,
	input  logic [abbt_pkg::IDX_W-1:0]    cfg_index,
	input  logic [abbt_pkg::REG_W-1:0]    cfg_data
);

	localparam int CNT_W = $clog2(WINDOW);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);
	localparam logic [abbt_pkg::AVG_SHIFT-1:0] RECIP =
		abbt_pkg::AVG_SHIFT'(((64'd1 << abbt_pkg::AVG_SHIFT) + WINDOW - 1) / WINDOW);
	localparam int MUL_W = abbt_pkg::SUM_W + abbt_pkg::AVG_SHIFT;

	logic [abbt_pkg::REG_W-1:0]  setpoint_q;
	logic [abbt_pkg::REG_W-1:0]  band_q;

	logic                        adv;
	logic                        v_s1, v_s2, v_s3;
	logic [abbt_pkg::ADC_W-1:0]  adc_s1;
	logic [abbt_pkg::TEMP_W-1:0] temp_c;
	logic [abbt_pkg::TEMP_W-1:0] temp_s2;
	logic [abbt_pkg::SUM_W-1:0]  sum_q;
	logic [abbt_pkg::SUM_W-1:0]  sum_nxt;
	logic [abbt_pkg::SUM_W-1:0]  sum_s3;
	logic [CNT_W-1:0]            cnt_q;

	logic [MUL_W-1:0]            mean_prod;
	logic [abbt_pkg::TEMP_W-1:0] mean;
	logic [abbt_pkg::REG_W:0]    hi_lim;
	logic                        go_cool, go_heat;

	logic                        out_valid_q;
	logic [abbt_pkg::TEMP_W-1:0] avg_q;
	logic                        fan_q, heater_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= abbt_pkg::SETPOINT_RST;
			band_q     <= abbt_pkg::BAND_RST;
		end else if (cfg_we) begin
			case (abbt_pkg::cfg_reg_t'(cfg_index))
				abbt_pkg::REG_SETPOINT: setpoint_q <= cfg_data;
				abbt_pkg::REG_BAND:     band_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign adv           = !out_valid_q || results.ready;
	assign samples.ready = adv;

	// stage 1: input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (adv)
			v_s1 <= samples.valid;
	end

	always_ff @(posedge clk) begin
		if (adv && samples.valid)
			adc_s1 <= samples.adc_sample;
	end

	abbt_adc_conv u_conv (
		.adc  (adc_s1),
		.temp (temp_c)
	);

	// stage 2: converted temperature
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1)
			temp_s2 <= temp_c;
	end

	// window accumulation
	assign sum_nxt = sum_q + abbt_pkg::SUM_W'(temp_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			v_s3  <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2 && (cnt_q == CNT_LAST);
			if (v_s2) begin
				if (cnt_q == CNT_LAST) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_nxt;
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2 && (cnt_q == CNT_LAST))
			sum_s3 <= sum_nxt;
	end

	// stage 3: mean by reciprocal multiply, hysteresis decision
	assign mean_prod = MUL_W'(sum_s3) * MUL_W'(RECIP);
	assign mean      = mean_prod[abbt_pkg::AVG_SHIFT +: abbt_pkg::TEMP_W];
	assign hi_lim    = {1'b0, setpoint_q} + {1'b0, band_q};
	assign go_cool   = {1'b0, mean} > hi_lim;
	assign go_heat   = ({1'b0, mean} + {1'b0, band_q}) < {1'b0, setpoint_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fan_q       <= 1'b0;
			heater_q    <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s3;
			if (v_s3) begin
				if (go_cool) begin
					fan_q    <= 1'b1;
					heater_q <= 1'b0;
				end else if (go_heat) begin
					fan_q    <= 1'b0;
					heater_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s3)
			avg_q <= mean;
	end

	assign results.valid        = out_valid_q;
	assign results.average_temp = avg_q;
	assign results.fan_on       = fan_q;
	assign results.heater_on    = heater_q;

	// fan and heater are never driven together
	a_drive_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(fan_q && heater_q))
		else $error("fan and heater both on");

	// reading count stays inside the window
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("sample count beyond window");

	// partial sum is bounded by the readings taken so far
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= abbt_pkg::SUM_W'(cnt_q) * abbt_pkg::SUM_W'(abbt_pkg::TEMP_MAX))
		else $error("window sum out of range");

	// a closed window reaches the result register on the next advance
	a_close_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && adv) |=> out_valid_q)
		else $error("closed window lost");

	// drives change only when a result is loaded
	a_drive_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s3 && adv) |=> ($stable(fan_q) && $stable(heater_q)))
		else $error("drive changed without a result");

endmodule

### src/abbt_adc_conv.sv
// Converter reading to whole degrees: floor(adc * 500 / 1023), saturated at 255.
`timescale 1ns / 1ps

module abbt_adc_conv (
	input  logic [abbt_pkg::ADC_W-1:0]  adc,
	output logic [abbt_pkg::TEMP_W-1:0] temp
);

	logic [abbt_pkg::PROD_W-1:0]          prod;
	logic [abbt_pkg::PROD_W-abbt_pkg::DIV_W-1:0] q0;
	logic [abbt_pkg::DIV_W:0]             rem;
	logic [abbt_pkg::PROD_W-abbt_pkg::DIV_W-1:0] quo;

	// x / 1023: x = 1024*q0 + lo = 1023*q0 + (lo + q0), with lo + q0 < 2*1023
	assign prod = abbt_pkg::PROD_W'(adc) * abbt_pkg::PROD_W'(abbt_pkg::MV_SCALE);
	assign q0   = prod[abbt_pkg::PROD_W-1:abbt_pkg::DIV_W];
	assign rem  = {1'b0, prod[abbt_pkg::DIV_W-1:0]} + (abbt_pkg::DIV_W+1)'(q0);
	assign quo  = (rem >= abbt_pkg::ADC_DIV) ? q0 + 1'b1 : q0;

	assign temp = (quo > (abbt_pkg::PROD_W-abbt_pkg::DIV_W)'(abbt_pkg::TEMP_MAX)) ?
		abbt_pkg::TEMP_MAX : quo[abbt_pkg::TEMP_W-1:0];

endmodule

### sim/averaged_bang_bang_thermostat_test.sv
// Self-checking testbench for the averaged bang-bang thermostat.
`timescale 1ns / 1ps

module averaged_bang_bang_thermostat_test;

	localparam int WINDOW       = 10;
	localparam int DRAIN_CYCLES = 8;
	localparam int LONG_HOLD    = 200;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 425;

	typedef struct packed {
		logic [abbt_pkg::TEMP_W-1:0] mean;
		logic                        fan;
		logic                        heater;
	} thermo_result_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_CONFIG
	} row_kind_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic [abbt_pkg::ADC_W-1:0] adc;
		logic [4:0]                 reps;
		logic [abbt_pkg::REG_W-1:0] setpoint;
		logic [abbt_pkg::REG_W-1:0] band;
		logic                       typed;
		thermo_result_t             want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [abbt_pkg::IDX_W-1:0] cfg_index;
	logic [abbt_pkg::REG_W-1:0] cfg_data;

	abbt_sample_if samples_if ();
	abbt_result_if results_if ();

	averaged_bang_bang_thermostat #(
		.WINDOW(WINDOW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [abbt_pkg::REG_W-1:0] setpoint_cfg;
	logic [abbt_pkg::REG_W-1:0] band_cfg;
	logic [abbt_pkg::SUM_W-1:0] sum_acc;
	logic [4:0]                 count_acc;
	logic                       fan_drive;
	logic                       heater_drive;
	int                         window_level;

	thermo_result_t windows_due[$];
	int  mismatches;
	int  readings_sent;
	int  windows_closed;
	int  windows_checked;
	int  settings_loaded;
	bit  hold_off_req;

	// Hot readings saturate, and a low setpoint never heats.
	stim_row_t directed_rows [8] = '{
		'{ROW_SAMPLE, 10'd1023, 5'd10, 8'd0,   8'd0,   1'b1, '{8'd255, 1'b1, 1'b0}},
		'{ROW_CONFIG, 10'd0,    5'd0,  8'd0,   8'd255, 1'b0, '{8'd0,   1'b0, 1'b0}},
		'{ROW_SAMPLE, 10'd0,    5'd10, 8'd0,   8'd0,   1'b1, '{8'd0,   1'b1, 1'b0}},
		'{ROW_SAMPLE, 10'd522,  5'd1,  8'd0,   8'd0,   1'b0, '{8'd0,   1'b0, 1'b0}},
		'{ROW_SAMPLE, 10'd523,  5'd1,  8'd0,   8'd0,   1'b0, '{8'd0,   1'b0, 1'b0}},
		'{ROW_SAMPLE, 10'd1,    5'd1,  8'd0,   8'd0,   1'b0, '{8'd0,   1'b0, 1'b0}},
		'{ROW_SAMPLE, 10'd1022, 5'd1,  8'd0,   8'd0,   1'b0, '{8'd0,   1'b0, 1'b0}},
		'{ROW_SAMPLE, 10'd512,  5'd1,  8'd0,   8'd0,   1'b0, '{8'd0,   1'b0, 1'b0}}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [abbt_pkg::TEMP_W-1:0] adc_degrees(
		input logic [abbt_pkg::ADC_W-1:0] adc);
		int unsigned mv;
		int unsigned deg;
		mv  = (int'(adc) * 5000) / 1023;
		deg = mv / 10;
		return (deg > 255) ? abbt_pkg::TEMP_MAX : deg[abbt_pkg::TEMP_W-1:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int degrees_to_adc(input int deg);
		int a;
		if (deg < 0)
			deg = 0;
		if (deg > 255)
			deg = 255;
		a = (deg * 1023 + 499) / 500;
		return (a > 1023) ? 1023 : a;
	endfunction

	// Most windows settle on one level, and half of all windows sit near the hysteresis edges.
	function automatic logic [abbt_pkg::ADC_W-1:0] next_reading();
		int mode;
		int a;
		if (count_acc == 0) begin
			mode = $urandom_range(0, 9);
			if (mode < 5) begin
				if ($urandom_range(0, 1))
					window_level = degrees_to_adc(int'(setpoint_cfg) + int'(band_cfg)
						+ $urandom_range(0, 4) - 2);
				else
					window_level = degrees_to_adc(int'(setpoint_cfg) - int'(band_cfg)
						+ $urandom_range(0, 4) - 2);
			end else if (mode < 7) begin
				window_level = -1;
			end else if (mode == 7) begin
				window_level = $urandom_range(520, 1023);
			end else if (mode == 8) begin
				window_level = $urandom_range(0, 40);
			end else begin
				window_level = degrees_to_adc(int'(setpoint_cfg)
					+ $urandom_range(0, 2 * int'(band_cfg)) - int'(band_cfg));
			end
		end
		if (window_level < 0 || $urandom_range(0, 7) == 0)
			return abbt_pkg::ADC_W'($urandom_range(0, 1023));
		a = window_level + $urandom_range(0, 6) - 3;
		if (a < 0)
			a = 0;
		if (a > 1023)
			a = 1023;
		return a[abbt_pkg::ADC_W-1:0];
	endfunction

	task automatic accumulate_reading(input logic [abbt_pkg::ADC_W-1:0] adc, input bit typed,
		input thermo_result_t want);
		thermo_result_t r;
		logic [abbt_pkg::TEMP_W-1:0] mean;
		int hi;
		int lo;
		sum_acc   = sum_acc + abbt_pkg::SUM_W'(adc_degrees(adc));
		count_acc = count_acc + 5'd1;
		readings_sent++;
		if (count_acc >= WINDOW) begin
			mean = abbt_pkg::TEMP_W'(sum_acc / WINDOW);
			sum_acc   = '0;
			count_acc = '0;
			hi = int'(setpoint_cfg) + int'(band_cfg);
			lo = int'(setpoint_cfg) - int'(band_cfg);
			if (int'(mean) > hi) begin
				fan_drive    = 1'b1;
				heater_drive = 1'b0;
			end else if (int'(mean) < lo) begin
				fan_drive    = 1'b0;
				heater_drive = 1'b1;
			end
			r = '{mean, fan_drive, heater_drive};
			windows_due.push_back(typed ? want : r);
			windows_closed++;
		end
	endtask

	task automatic push_sample(input logic [abbt_pkg::ADC_W-1:0] adc, input bit typed,
		input thermo_result_t want);
		samples_if.valid      <= 1'b1;
		samples_if.adc_sample <= adc;
		do
			@(posedge clk);
		while (!(samples_if.valid && samples_if.ready));
		accumulate_reading(adc, typed, want);
	endtask

	task automatic idle_sender();
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		samples_if.valid <= 1'b0;
		while (windows_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_thresholds(input logic [abbt_pkg::REG_W-1:0] sp,
		input logic [abbt_pkg::REG_W-1:0] bw);
		cfg_we    <= 1'b1;
		cfg_index <= abbt_pkg::REG_SETPOINT;
		cfg_data  <= sp;
		@(posedge clk);
		setpoint_cfg = sp;
		cfg_index <= abbt_pkg::REG_BAND;
		cfg_data  <= bw;
		@(posedge clk);
		band_cfg = bw;
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_result
		thermo_result_t due;
		if (results_if.valid && results_if.ready) begin
			if (windows_due.size() == 0) begin
				report_mismatch($sformatf("result with no window pending (mean %0d)",
					results_if.average_temp));
			end else begin
				due = windows_due.pop_front();
				if (results_if.average_temp !== due.mean)
					report_mismatch($sformatf("window %0d mean %0d, expected %0d",
						windows_checked, results_if.average_temp, due.mean));
				if (results_if.fan_on !== due.fan)
					report_mismatch($sformatf("window %0d fan %0b, expected %0b",
						windows_checked, results_if.fan_on, due.fan));
				if (results_if.heater_on !== due.heater)
					report_mismatch($sformatf("window %0d heater %0b, expected %0b",
						windows_checked, results_if.heater_on, due.heater));
				windows_checked++;
			end
		end
	end

	initial begin : result_sink
		int gap;
		results_if.ready = 1'b0;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				results_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap > 0) begin
					results_if.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				results_if.ready <= 1'b1;
				if ($urandom_range(0, 7) == 0)
					repeat ($urandom_range(30, 80)) @(posedge clk);
				else
					repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int phase;
		int n;
		int random_sent;
		bit no_gaps;
		logic [abbt_pkg::REG_W-1:0] sp;
		logic [abbt_pkg::REG_W-1:0] bw;

		samples_if.valid      = 1'b0;
		samples_if.adc_sample = '0;
		cfg_we       = 1'b0;
		cfg_index    = abbt_pkg::REG_SETPOINT;
		cfg_data     = '0;
		arst_n       = 1'b0;
		hold_off_req = 1'b0;
		setpoint_cfg = abbt_pkg::SETPOINT_RST;
		band_cfg     = abbt_pkg::BAND_RST;
		sum_acc      = '0;
		count_acc    = '0;
		fan_drive    = 1'b0;
		heater_drive = 1'b0;
		window_level = -1;
		mismatches      = 0;
		readings_sent   = 0;
		windows_closed  = 0;
		windows_checked = 0;
		settings_loaded = 0;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CONFIG) begin
				drain_results();
				load_thresholds(directed_rows[i].setpoint, directed_rows[i].band);
			end else begin
				for (int k = 0; k < directed_rows[i].reps; k++)
					push_sample(directed_rows[i].adc,
						directed_rows[i].typed && (k == directed_rows[i].reps - 1),
						directed_rows[i].want);
				idle_sender();
			end
		end

		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (phase)
				0: begin sp = 8'd255; bw = 8'd255; end
				1: begin sp = 8'd0;   bw = 8'd0;   end
				2: begin sp = 8'd0;   bw = 8'd255; end
				3: begin sp = 8'd255; bw = 8'd0;   end
				4: begin sp = abbt_pkg::SETPOINT_RST; bw = abbt_pkg::BAND_RST; end
				default: begin
					sp = abbt_pkg::REG_W'($urandom_range(0, 255));
					bw = abbt_pkg::REG_W'($urandom_range(0, 1) ? $urandom_range(0, 40)
						: $urandom_range(0, 255));
				end
			endcase
			drain_results();
			load_thresholds(sp, bw);
			// stall the result side long enough to back up the sample side
			if (phase == 2) begin
				hold_off_req = 1'b1;
				wait (!hold_off_req);
			end
			n = (phase == 2) ? 50 : $urandom_range(10, 45);
			if (n > RANDOM_ITEMS - random_sent)
				n = RANDOM_ITEMS - random_sent;
			no_gaps = (phase == 2) || ($urandom_range(0, 3) == 0);
			repeat (n) begin
				push_sample(next_reading(), 1'b0, '0);
				if (!no_gaps)
					idle_sender();
			end
			random_sent += n;
			phase++;
		end
		drain_results();

		$display("Ran %0d readings in %0d windows over %0d threshold settings; %0d checked.",
			readings_sent, windows_closed, settings_loaded, windows_checked);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
